// ===== hw/rtl/fbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_pkg
// Types, constants and font table for the rectangle and glyph draw engine.
// ----------------------------------------------------------------------------
package fbd_pkg;

   localparam int FRAME_WIDTH_DEF  = 240;
   localparam int FRAME_HEIGHT_DEF = 135;
   localparam int MAX_SCALE_DEF    = 8;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 11;

   localparam logic [7:0] GLYPH_FIRST = 8'h20;
   localparam logic [7:0] GLYPH_LAST  = 8'h7E;
   localparam logic [7:0] GLYPH_SUB   = 8'h3F;
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 8;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_GLYPH = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [10:0]        rect_w;
      logic [10:0]        rect_h;
      logic [7:0]         char_code;
      logic [3:0]         glyph_scale;
      logic [15:0]        color;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic        in_frame;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PAINT,
      ST_NEXT_DOT,
      ST_READ,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic setup_box;
      logic paint_step;
      logic dot_step;
      logic read_issue;
      logic result_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_fill;
      logic is_glyph;
      logic is_read;
      logic box_empty;
      logic box_last;
      logic dot_last;
   } sts_type;

   function automatic logic [39:0] font_row(input logic [6:0] idx);
      logic [39:0] f;
      unique case (idx)
         7'd0: f = 40'h0000000000; 7'd1: f = 40'h00005F0000;
         7'd2: f = 40'h0007000700; 7'd3: f = 40'h147F147F14;
         7'd4: f = 40'h242A7F2A12; 7'd5: f = 40'h2313086462;
         7'd6: f = 40'h3649562050; 7'd7: f = 40'h0008070300;
         7'd8: f = 40'h001C224100; 7'd9: f = 40'h0041221C00;
         7'd10: f = 40'h2A1C7F1C2A; 7'd11: f = 40'h08083E0808;
         7'd12: f = 40'h0080703000; 7'd13: f = 40'h0808080808;
         7'd14: f = 40'h0000606000; 7'd15: f = 40'h2010080402;
         7'd16: f = 40'h3E5149453E; 7'd17: f = 40'h00427F4000;
         7'd18: f = 40'h7249494946; 7'd19: f = 40'h2141494D33;
         7'd20: f = 40'h1814127F10; 7'd21: f = 40'h2745454539;
         7'd22: f = 40'h3C4A494931; 7'd23: f = 40'h4121110907;
         7'd24: f = 40'h3649494936; 7'd25: f = 40'h464949291E;
         7'd26: f = 40'h0000140000; 7'd27: f = 40'h0040340000;
         7'd28: f = 40'h0008142241; 7'd29: f = 40'h1414141414;
         7'd30: f = 40'h0041221408; 7'd31: f = 40'h0201590906;
         7'd32: f = 40'h3E415D594E; 7'd33: f = 40'h7C1211127C;
         7'd34: f = 40'h7F49494936; 7'd35: f = 40'h3E41414122;
         7'd36: f = 40'h7F4141413E; 7'd37: f = 40'h7F49494941;
         7'd38: f = 40'h7F09090901; 7'd39: f = 40'h3E41415173;
         7'd40: f = 40'h7F0808087F; 7'd41: f = 40'h00417F4100;
         7'd42: f = 40'h2040413F01; 7'd43: f = 40'h7F08142241;
         7'd44: f = 40'h7F40404040; 7'd45: f = 40'h7F021C027F;
         7'd46: f = 40'h7F0408107F; 7'd47: f = 40'h3E4141413E;
         7'd48: f = 40'h7F09090906; 7'd49: f = 40'h3E4151215E;
         7'd50: f = 40'h7F09192946; 7'd51: f = 40'h2649494932;
         7'd52: f = 40'h03017F0103; 7'd53: f = 40'h3F4040403F;
         7'd54: f = 40'h1F2040201F; 7'd55: f = 40'h3F4038403F;
         7'd56: f = 40'h6314081463; 7'd57: f = 40'h0304780403;
         7'd58: f = 40'h6159494D43; 7'd59: f = 40'h007F414141;
         7'd60: f = 40'h0204081020; 7'd61: f = 40'h004141417F;
         7'd62: f = 40'h0402010204; 7'd63: f = 40'h4040404040;
         7'd64: f = 40'h0003070800; 7'd65: f = 40'h2054547840;
         7'd66: f = 40'h7F28444438; 7'd67: f = 40'h3844444428;
         7'd68: f = 40'h384444287F; 7'd69: f = 40'h3854545418;
         7'd70: f = 40'h00087E0902; 7'd71: f = 40'h18A4A49C78;
         7'd72: f = 40'h7F08040478; 7'd73: f = 40'h00447D4000;
         7'd74: f = 40'h2040403D00; 7'd75: f = 40'h7F10284400;
         7'd76: f = 40'h00417F4000; 7'd77: f = 40'h7C04780478;
         7'd78: f = 40'h7C08040478; 7'd79: f = 40'h3844444438;
         7'd80: f = 40'hFC18242418; 7'd81: f = 40'h18242418FC;
         7'd82: f = 40'h7C08040408; 7'd83: f = 40'h4854545424;
         7'd84: f = 40'h04043F4424; 7'd85: f = 40'h3C4040207C;
         7'd86: f = 40'h1C2040201C; 7'd87: f = 40'h3C4030403C;
         7'd88: f = 40'h4428102844; 7'd89: f = 40'h4C9090907C;
         7'd90: f = 40'h4464544C44; 7'd91: f = 40'h0008364100;
         7'd92: f = 40'h0000770000; 7'd93: f = 40'h0041360800;
         7'd94: f = 40'h0201020402;
         default: f = 40'h0000000000;
      endcase
      return f;
   endfunction

endpackage

// ===== hw/rtl/fbd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_ctrl
// Command sequencer: accepts a request, steps the datapath, returns a result.
// ----------------------------------------------------------------------------
module fbd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  fbd_pkg::sts_type sts,
   output fbd_pkg::cmd_type cmd
);
   import fbd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            priority if (sts.is_read) begin
               cmd.read_issue = 1'b1;
               state_in       = ST_READ;
            end else if (sts.is_fill || sts.is_glyph) begin
               cmd.setup_box = 1'b1;
               state_in      = ST_PAINT;
            end else begin
               cmd.result_load = 1'b1;
               state_in        = ST_RESULT;
            end
         end
         ST_PAINT: begin
            cmd.paint_step = 1'b1;
            if (sts.box_empty || sts.box_last) begin
               state_in = ST_NEXT_DOT;
            end
         end
         ST_NEXT_DOT: begin
            if (sts.is_glyph && !sts.dot_last) begin
               cmd.dot_step = 1'b1;
               state_in     = ST_SETUP;
            end else begin
               cmd.result_load = 1'b1;
               state_in        = ST_RESULT;
            end
         end
         ST_READ: begin
            cmd.result_load = 1'b1;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/fbd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_datapath
// Clipping, dot walk, pixel address generation and the frame store.
// ----------------------------------------------------------------------------
module fbd_datapath #(
   parameter int FRAME_WIDTH  = fbd_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = fbd_pkg::FRAME_HEIGHT_DEF,
   parameter int MAX_SCALE    = fbd_pkg::MAX_SCALE_DEF
) (
   input  logic             clock,
   input  fbd_pkg::req_type req_data,
   input  fbd_pkg::cmd_type cmd,
   output fbd_pkg::sts_type sts,
   output fbd_pkg::rsp_type rsp_data
);
   import fbd_pkg::*;

   localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(FRAME_WIDTH + 1);
   localparam int YW    = $clog2(FRAME_HEIGHT + 1);
   localparam int SW    = $clog2(MAX_SCALE + 1);
   // wide enough for coordinate plus span plus glyph offset
   localparam int CW    = 16;

   logic [15:0] mem [DEPTH];

   req_type req_ff;
   logic [39:0] font_ff;
   logic [SW-1:0] scale_ff;
   logic [2:0] col_ff, row_ff;
   logic [XW-1:0] x0_ff, x1_ff, cx_ff;
   logic [YW-1:0] y1_ff, cy_ff;
   logic [AW-1:0] row_base_ff;
   logic empty_ff;
   logic [15:0] rd_ff;
   logic read_in_ff;
   rsp_type rsp_ff;

   logic [7:0] code;
   logic [3:0] scl_sat;
   logic signed [CW-1:0] bx, by, bw, bh, ex, ey;
   logic signed [CW-1:0] cx0, cy0, cx1, cy1;
   logic dot_on;
   logic [7:0] col_bits;
   logic rd_inside;
   logic [AW-1:0] rd_addr;

   assign code = (req_data.char_code < GLYPH_FIRST || req_data.char_code > GLYPH_LAST)
                 ? GLYPH_SUB : req_data.char_code;
   assign scl_sat = (req_data.glyph_scale > 4'(MAX_SCALE > 15 ? 15 : MAX_SCALE))
                    ? 4'(MAX_SCALE > 15 ? 15 : MAX_SCALE) : req_data.glyph_scale;

   always_comb begin
      col_bits = font_ff[8*(4-col_ff) +: 8];
      dot_on   = col_bits[row_ff];
      if (req_ff.kind == KIND_FILL) begin
         bx = CW'(req_ff.pos_x);
         by = CW'(req_ff.pos_y);
         bw = CW'({1'b0, req_ff.rect_w});
         bh = CW'({1'b0, req_ff.rect_h});
      end else begin
         bx = CW'(req_ff.pos_x) + CW'(col_ff) * CW'({1'b0, scale_ff});
         by = CW'(req_ff.pos_y) + CW'(row_ff) * CW'({1'b0, scale_ff});
         bw = CW'({1'b0, scale_ff});
         bh = bw;
      end
      ex  = bx + bw;
      ey  = by + bh;
      cx0 = (bx < 0) ? '0 : bx;
      cy0 = (by < 0) ? '0 : by;
      cx1 = (ex > CW'(FRAME_WIDTH)) ? CW'(FRAME_WIDTH) : ex;
      cy1 = (ey > CW'(FRAME_HEIGHT)) ? CW'(FRAME_HEIGHT) : ey;
      rd_inside = req_ff.pos_x >= 0 && CW'(req_ff.pos_x) < CW'(FRAME_WIDTH)
               && req_ff.pos_y >= 0 && CW'(req_ff.pos_y) < CW'(FRAME_HEIGHT);
      rd_addr = AW'(req_ff.pos_y[10:0] * FRAME_WIDTH) + AW'(req_ff.pos_x[10:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_data;
         font_ff  <= font_row(7'(code - GLYPH_FIRST));
         scale_ff <= SW'(scl_sat);
         col_ff   <= '0;
         row_ff   <= '0;
      end
      if (cmd.setup_box) begin
         empty_ff <= (cx0 >= cx1) || (cy0 >= cy1)
                  || (req_ff.kind == KIND_GLYPH && (scale_ff == '0 || !dot_on));
         x0_ff <= XW'(cx0);
         x1_ff <= XW'(cx1);
         y1_ff <= YW'(cy1);
         cx_ff <= XW'(cx0);
         cy_ff <= YW'(cy0);
         row_base_ff <= AW'(cy0 * FRAME_WIDTH);
      end
      if (cmd.paint_step && !empty_ff) begin
         mem[row_base_ff + AW'(cx_ff)] <= req_ff.color;
         if (cx_ff + 1'b1 == x1_ff) begin
            cx_ff       <= x0_ff;
            cy_ff       <= cy_ff + 1'b1;
            row_base_ff <= row_base_ff + AW'(FRAME_WIDTH);
         end else begin
            cx_ff <= cx_ff + 1'b1;
         end
      end
      if (cmd.dot_step) begin
         if (row_ff == 3'(GLYPH_ROWS - 1)) begin
            row_ff <= '0;
            col_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
      if (cmd.read_issue) begin
         rd_ff      <= mem[rd_addr];
         read_in_ff <= rd_inside;
      end
      if (cmd.result_load) begin
         rsp_ff.pixel_value <= (req_ff.kind == KIND_READ && read_in_ff) ? rd_ff : '0;
         rsp_ff.in_frame    <= req_ff.kind == KIND_READ && read_in_ff;
      end
   end

   assign sts.is_fill   = req_ff.kind == KIND_FILL;
   assign sts.is_glyph  = req_ff.kind == KIND_GLYPH;
   assign sts.is_read   = req_ff.kind == KIND_READ;
   assign sts.box_empty = empty_ff;
   assign sts.box_last  = (cx_ff + 1'b1 == x1_ff) && (cy_ff + 1'b1 == y1_ff);
   assign sts.dot_last  = col_ff == 3'(GLYPH_COLS - 1) && row_ff == 3'(GLYPH_ROWS - 1);
   assign rsp_data      = rsp_ff;

endmodule

// ===== hw/rtl/framebuffer_rect_and_glyph_draw.sv =====
`timescale 1ns / 1ps
// a read passes through the setup, read and result states; a fill through setup,
//   paint over its clipped pixels, next-dot and result; a glyph repeats setup,
//   paint and next-dot for each of its 40 dots and then gives its result
// throughput: one request at a time, one frame store write per cycle
// synchronous active-high reset returns the sequencer to idle; the frame
//   store is not cleared and must be written before it is read
// ----------------------------------------------------------------------------
// framebuffer_rect_and_glyph_draw
// Rectangle fill, 5x8 glyph draw and pixel read over a 16-bit frame store.
// ----------------------------------------------------------------------------
module framebuffer_rect_and_glyph_draw #(
   parameter int FRAME_WIDTH  = fbd_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = fbd_pkg::FRAME_HEIGHT_DEF,
   parameter int MAX_SCALE    = fbd_pkg::MAX_SCALE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fbd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fbd_pkg::rsp_type rsp_data
);
   import fbd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbd_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .MAX_SCALE    (MAX_SCALE)
   ) u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hw/rtl/fbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_checker
// Port-level checks for the draw engine.
// ----------------------------------------------------------------------------
module fbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fbd_pkg::rsp_type rsp_data
);
   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // one request in flight: no acceptance while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   // in_frame clear implies zero pixel
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_frame |-> rsp_data.pixel_value == 16'd0)
      else $error("nonzero pixel outside frame");

   // an accepted request never yields a result on the next edge
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early");

endmodule

bind framebuffer_rect_and_glyph_draw fbd_checker u_fbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
